// ----- sv/point_transform_pinhole_cull_assert.svh -----
// Assertion macros for the point transform and cull block.
// Used by the port checker; depends on nothing else.
`ifndef POINT_TRANSFORM_PINHOLE_CULL_ASSERT_SVH
`define POINT_TRANSFORM_PINHOLE_CULL_ASSERT_SVH

// Same-cycle implication, disabled while dis is high.
`define PTPC_ASSERT_IMPLY(lbl, ck, dis, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (dis) (ante) |-> (cons)) \
    else $error("ptpc check failed");

// Next-cycle implication, disabled while dis is high.
`define PTPC_ASSERT_NEXT(lbl, ck, dis, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (dis) (ante) |=> (cons)) \
    else $error("ptpc check failed");

`endif

// ----- sv/ptpc_pkg.sv -----
// Shared types and constants of the point transform and cull block.
// No dependencies.
`default_nettype none
package ptpc_pkg;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
  } cam_t;

  // Rigid transform settings, as written to the registers
  typedef struct packed {
    logic [53:0] row0;
    logic [53:0] row1;
    logic [53:0] row2;
    logic [62:0] trans;
  } xform_t;

  // Projection settings
  typedef struct packed {
    logic [31:0] fx;
    logic [31:0] fy;
    logic [27:0] cx;
    logic [27:0] cy;
    logic [11:0] width;
    logic [11:0] height;
  } view_t;

  localparam int CFG_W   = 64;
  localparam int INDEX_W = 3;

  localparam logic [INDEX_W-1:0] REG_FOCAL  = 3'd0;
  localparam logic [INDEX_W-1:0] REG_CENTRE = 3'd1;
  localparam logic [INDEX_W-1:0] REG_SIZE   = 3'd2;
  localparam logic [INDEX_W-1:0] REG_ROT0   = 3'd3;
  localparam logic [INDEX_W-1:0] REG_ROT1   = 3'd4;
  localparam logic [INDEX_W-1:0] REG_ROT2   = 3'd5;
  localparam logic [INDEX_W-1:0] REG_TRANS  = 3'd6;

  localparam logic [23:0] SIZE_RESET = 24'd1966720;             // 640 x 480
  localparam logic [53:0] ROT0_RESET = 54'd65536;               // identity rows
  localparam logic [53:0] ROT1_RESET = 54'd17179869184;
  localparam logic [53:0] ROT2_RESET = 54'd4503599627370496;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

endpackage
`default_nettype wire

// ----- sv/ptpc_front.sv -----
// Front end: accepts points, applies the rigid transform, rounds, saturates
// and drops points whose depth is not positive. Depends on ptpc_pkg.
`default_nettype none
module ptpc_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire ptpc_pkg::point_t        point,
  input  wire ptpc_pkg::xform_t        xform,
  input  wire logic [ptpc_pkg::QCNT_W-1:0] q_count,
  output logic                         push,
  output ptpc_pkg::cam_t               push_data
);
  import ptpc_pkg::*;

  function automatic logic signed [31:0] sat32(input logic signed [36:0] r);
    logic signed [31:0] res;
    if (r > 37'sh0_7FFF_FFFF) begin
      res = 32'sh7FFF_FFFF;
    end else if (r < 37'sh1F_8000_0000) begin
      res = 32'sh8000_0000;
    end else begin
      res = r[31:0];
    end
    return res;
  endfunction

  logic accept;
  logic f1_valid, f2_valid;
  logic [QCNT_W-1:0] occupancy;
  logic signed [49:0] prod [3][3];
  logic signed [52:0] acc [3];
  logic signed [36:0] rnd [3];
  logic signed [31:0] sat [3];
  logic signed [17:0] coef [3][3];
  logic signed [36:0] toff [3];
  cam_t f2_cam;

  // Credit check: queue entries plus points still in flight
  assign occupancy = q_count + QCNT_W'(f1_valid) + QCNT_W'(f2_valid);
  assign in_stall  = (occupancy >= QCNT_W'(QDEPTH));
  assign accept    = in_valid && !in_stall;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      coef[0][c] = $signed(xform.row0[18*c +: 18]);
      coef[1][c] = $signed(xform.row1[18*c +: 18]);
      coef[2][c] = $signed(xform.row2[18*c +: 18]);
    end
    for (int r = 0; r < 3; r++) begin
      toff[r] = $signed({xform.trans[21*r +: 21], 16'h0000});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else begin
      f1_valid <= accept;
      f2_valid <= f1_valid && (sat[2] > 32'sd0);
    end
  end

  // Stage one: nine coefficient products
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int r = 0; r < 3; r++) begin
        prod[r][0] <= coef[r][0] * point.point_x;
        prod[r][1] <= coef[r][1] * point.point_y;
        prod[r][2] <= coef[r][2] * point.point_z;
      end
    end
  end

  // Stage two: sum, round half up, saturate
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = 53'(prod[r][0]) + 53'(prod[r][1]) + 53'(prod[r][2])
             + 53'(toff[r]) + 53'sd32768;
      rnd[r] = acc[r][52:16];
      sat[r] = sat32(rnd[r]);
    end
  end

  always_ff @(posedge clk) begin
    f2_cam.cam_x <= sat[0];
    f2_cam.cam_y <= sat[1];
    f2_cam.cam_z <= sat[2];
  end

  assign push      = f2_valid;
  assign push_data = f2_cam;

endmodule
`default_nettype wire

// ----- sv/ptpc_queue.sv -----
// Short queue between front and back end of the transform block.
// Depends on ptpc_pkg.
`default_nettype none
module ptpc_queue (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire ptpc_pkg::cam_t              push_data,
  input  wire logic                        pop,
  output logic                             q_valid,
  output ptpc_pkg::cam_t                   q_head,
  output logic [ptpc_pkg::QCNT_W-1:0]      q_count
);
  import ptpc_pkg::*;

  cam_t entry [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

  assign q_valid = (count != '0);
  assign q_head  = entry[rd_ptr];
  assign q_count = count;

endmodule
`default_nettype wire

// ----- sv/ptpc_back.sv -----
// Back end: exact pinhole visibility test by cross-multiplying with depth,
// and the output register. Depends on ptpc_pkg.
`default_nettype none
module ptpc_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire ptpc_pkg::cam_t   q_head,
  output logic                  pop,
  input  wire ptpc_pkg::view_t  view,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output ptpc_pkg::cam_t        cam
);
  import ptpc_pkg::*;

  logic adv;
  logic b1_valid;
  cam_t b1_cam;
  logic signed [64:0] fc_u, fc_v;
  logic [58:0] kz_u, kz_v;
  logic [42:0] bz_u, bz_v;
  logic signed [65:0] s_u, s_v;
  logic pass_u, pass_v;

  assign adv = !out_valid || !out_stall;
  assign pop = adv && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      b1_valid  <= q_valid;
      out_valid <= b1_valid && pass_u && pass_v;
    end
  end

  // Stage one: focal, centre and bound products (depth is positive here)
  always_ff @(posedge clk) begin
    if (adv) begin
      b1_cam <= q_head;
      fc_u   <= $signed({1'b0, view.fx}) * q_head.cam_x;
      fc_v   <= $signed({1'b0, view.fy}) * q_head.cam_y;
      kz_u   <= view.cx * q_head.cam_z[30:0];
      kz_v   <= view.cy * q_head.cam_z[30:0];
      bz_u   <= view.width * q_head.cam_z[30:0];
      bz_v   <= view.height * q_head.cam_z[30:0];
    end
  end

  always_comb begin
    s_u = 66'(fc_u) + $signed({7'b0, kz_u});
    s_v = 66'(fc_v) + $signed({7'b0, kz_v});
    pass_u = !s_u[65] && (s_u[64:0] < {6'b0, bz_u, 16'h0000});
    pass_v = !s_v[65] && (s_v[64:0] < {6'b0, bz_v, 16'h0000});
  end

  always_ff @(posedge clk) begin
    if (adv) cam <= b1_cam;
  end

endmodule
`default_nettype wire

// ----- sv/point_transform_pinhole_cull.sv -----
// Point transform and pinhole cull, top level: configuration registers and
// the front end, queue and back end. Depends on ptpc_pkg and its submodules.
//
// Takes one Q16.16 point per transfer, rotates and translates it into the
// camera frame (rounded half up, saturated to 32 bits) and passes it on only
// when its depth is positive and its projected pixel lies inside the image.
// The visibility test is exact and uses no divider: both sides are scaled by
// depth. One point is accepted every cycle while the output is not stalled.
// A point passes through two front stages (products, then sum and saturate),
// the four-entry queue and two back stages (cross products, then compare
// into the output register). The front grants input transfers on credit
// from the queue, so an output stall backs up the queue before it reaches
// the input. Configuration is written by index through cfg_write; unknown
// indexes are ignored. Write only while no point is in flight.
`default_nettype none
module point_transform_pinhole_cull (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire ptpc_pkg::point_t              point,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output ptpc_pkg::cam_t                     cam,
  input  wire logic                          cfg_write,
  input  wire logic [ptpc_pkg::INDEX_W-1:0]  cfg_index,
  input  wire logic [ptpc_pkg::CFG_W-1:0]    cfg_data
);
  import ptpc_pkg::*;

  logic [63:0] focal_pair;
  logic [55:0] centre_pair;
  logic [23:0] image_size;
  logic [53:0] rot_row0, rot_row1, rot_row2;
  logic [62:0] translation;

  xform_t xform;
  view_t  view;

  logic push, pop, q_valid;
  cam_t push_data, q_head;
  logic [QCNT_W-1:0] q_count;

  // Register writes: drop bits above each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      focal_pair  <= '0;
      centre_pair <= '0;
      image_size  <= SIZE_RESET;
      rot_row0    <= ROT0_RESET;
      rot_row1    <= ROT1_RESET;
      rot_row2    <= ROT2_RESET;
      translation <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FOCAL:  focal_pair  <= cfg_data;
        REG_CENTRE: centre_pair <= cfg_data[55:0];
        REG_SIZE:   image_size  <= cfg_data[23:0];
        REG_ROT0:   rot_row0    <= cfg_data[53:0];
        REG_ROT1:   rot_row1    <= cfg_data[53:0];
        REG_ROT2:   rot_row2    <= cfg_data[53:0];
        REG_TRANS:  translation <= cfg_data[62:0];
        default: ;
      endcase
    end
  end

  // Unpack fields for the two halves
  always_comb begin
    xform.row0   = rot_row0;
    xform.row1   = rot_row1;
    xform.row2   = rot_row2;
    xform.trans  = translation;
    view.fx      = focal_pair[31:0];
    view.fy      = focal_pair[63:32];
    view.cx      = centre_pair[27:0];
    view.cy      = centre_pair[55:28];
    view.width   = image_size[11:0];
    view.height  = image_size[23:12];
  end

  ptpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .point     (point),
    .xform     (xform),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  ptpc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_count   (q_count)
  );

  ptpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .view      (view),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cam       (cam)
  );

endmodule
`default_nettype wire

// ----- sv/ptpc_checker.sv -----
// Port checker for the point transform and cull block, bound to the top level.
// Depends on ptpc_pkg and point_transform_pinhole_cull_assert.svh.
`default_nettype none
`include "point_transform_pinhole_cull_assert.svh"
module ptpc_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            in_stall,
  input wire logic            out_valid,
  input wire logic            out_stall,
  input wire ptpc_pkg::cam_t  cam
);
  import ptpc_pkg::*;

  `PTPC_ASSERT_NEXT(out_held, clk, rst, out_valid && out_stall, out_valid)
  `PTPC_ASSERT_NEXT(cam_held, clk, rst, out_valid && out_stall, $stable(cam))
  `PTPC_ASSERT_IMPLY(depth_positive, clk, rst, out_valid, cam.cam_z > 32'sd0)
  `PTPC_ASSERT_NEXT(reset_idle, clk, 1'b0, rst, !out_valid && !in_stall)

endmodule

bind point_transform_pinhole_cull ptpc_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .cam       (cam)
);
`default_nettype wire

// ----- test/point_transform_pinhole_cull_checker.sv -----
// Checker for the point transform and pinhole cull block: mirrors the registers,
// predicts each camera-frame point and compares it with the output transfers.
// Depends on ptpc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module point_transform_pinhole_cull_checker
  import ptpc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire point_t             point,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire cam_t               cam,
  input  wire logic               cfg_write,
  input  wire logic [INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  output int                      fail_count,
  output int                      pending
);

  logic [63:0] focal;
  logic [55:0] centre;
  logic [23:0] img_size;
  logic [53:0] rot_row [3];
  logic [62:0] trans;

  cam_t visible_points [$];

  assign pending = visible_points.size();

  // One rounded, saturated camera-frame axis
  function automatic longint cam_axis(logic [53:0] row, logic [20:0] t,
                                      longint px, longint py, longint pz);
    longint acc;
    longint r;
    acc = longint'($signed(row[17:0])) * px + longint'($signed(row[35:18])) * py
        + longint'($signed(row[53:36])) * pz + longint'($signed(t)) * 65536;
    r = (acc + 32768) >>> 16;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  // Exact 0 <= f*c + k*z < lim*z*2^16, z > 0
  function automatic bit in_view(logic [31:0] f, longint c, logic [27:0] k,
                                 longint z, logic [11:0] lim);
    logic [79:0] s, kz, prod, bound;
    kz = 80'(k) * 80'(z);
    bound = (80'(lim) * 80'(z)) << 16;
    if (c >= 0) begin
      s = 80'(f) * 80'(c) + kz;
    end else begin
      prod = 80'(f) * 80'(-c);
      if (kz < prod) return 1'b0;
      s = kz - prod;
    end
    return s < bound;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    longint qx, qy, qz;
    cam_t c;
    cam_t want;
    if (rst) begin
      focal <= '0;
      centre <= '0;
      img_size <= SIZE_RESET;
      rot_row[0] <= ROT0_RESET;
      rot_row[1] <= ROT1_RESET;
      rot_row[2] <= ROT2_RESET;
      trans <= '0;
      fail_count = 0;
      visible_points.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FOCAL:  focal <= cfg_data;
          REG_CENTRE: centre <= cfg_data[55:0];
          REG_SIZE:   img_size <= cfg_data[23:0];
          REG_ROT0:   rot_row[0] <= cfg_data[53:0];
          REG_ROT1:   rot_row[1] <= cfg_data[53:0];
          REG_ROT2:   rot_row[2] <= cfg_data[53:0];
          REG_TRANS:  trans <= cfg_data[62:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        qx = cam_axis(rot_row[0], trans[20:0], point.point_x, point.point_y, point.point_z);
        qy = cam_axis(rot_row[1], trans[41:21], point.point_x, point.point_y, point.point_z);
        qz = cam_axis(rot_row[2], trans[62:42], point.point_x, point.point_y, point.point_z);
        if (qz > 0 && in_view(focal[31:0], qx, centre[27:0], qz, img_size[11:0]) &&
            in_view(focal[63:32], qy, centre[55:28], qz, img_size[23:12])) begin
          c.cam_x = qx[31:0];
          c.cam_y = qy[31:0];
          c.cam_z = qz[31:0];
          visible_points.insert(visible_points.size(), c);
        end
      end
      if (out_valid && !out_stall) begin
        if (visible_points.size() == 0) begin
          report("unexpected transfer, cam_z", cam.cam_z, 0);
        end else begin
          want = visible_points.pop_front();
          if (cam.cam_x !== want.cam_x) report("cam_x", cam.cam_x, want.cam_x);
          if (cam.cam_y !== want.cam_y) report("cam_y", cam.cam_y, want.cam_y);
          if (cam.cam_z !== want.cam_z) report("cam_z", cam.cam_z, want.cam_z);
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- test/point_transform_pinhole_cull_tb.sv -----
// Top of the point transform and pinhole cull testbench: clock, reset,
// configuration phases and point stimulus. Depends on ptpc_pkg, the block
// and point_transform_pinhole_cull_checker.
`timescale 1ns / 1ps
`default_nettype none
module point_transform_pinhole_cull_tb;
  import ptpc_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  point_t             point = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  cam_t               cam;
  logic               cfg_write = 1'b0;
  logic [INDEX_W-1:0] cfg_index = REG_FOCAL;
  logic [CFG_W-1:0]   cfg_data = '0;
  int                 fail_count;
  int                 pending;
  bit                 quiet = 1'b0;   // no idling on either side when set
  int                 stall_left = 0;

  always #2 clk = ~clk;

  point_transform_pinhole_cull u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .point(point),
    .out_valid(out_valid), .out_stall(out_stall), .cam(cam),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  point_transform_pinhole_cull_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .point(point),
    .out_valid(out_valid), .out_stall(out_stall), .cam(cam),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver back-pressure: stall bursts of random length
  always @(negedge clk) begin
    logic stall_next;
    stall_next = 1'b0;
    if (quiet) begin
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      stall_next = 1'b1;
    end else if ($urandom_range(3) == 0) begin
      stall_left = $urandom_range(4);
      stall_next = 1'b1;
    end
    out_stall <= stall_next;
  end

  // Hard stop for a hung run
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Pack three Q2.16 coefficients, column 0 lowest
  function automatic logic [63:0] rot_row(int c0, int c1, int c2);
    logic [17:0] a, b, c;
    a = c0[17:0];
    b = c1[17:0];
    c = c2[17:0];
    return {10'd0, c, b, a};
  endfunction

  function automatic logic [63:0] trans_triple(int tx, int ty, int tz);
    logic [20:0] a, b, c;
    a = tx[20:0];
    b = ty[20:0];
    c = tz[20:0];
    return {1'b0, c, b, a};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Drain: wait for every visible point, then let culled ones leave the pipe
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // Leave the enable high; the caller drops it after the last write
  task automatic write_reg(logic [INDEX_W-1:0] idx, logic [63:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  task automatic set_camera(logic [63:0] foc, logic [63:0] ctr, logic [63:0] sz,
                            logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                            logic [63:0] tr);
    drain();
    write_reg(REG_FOCAL, foc);
    write_reg(REG_CENTRE, ctr);
    write_reg(REG_SIZE, sz);
    write_reg(REG_ROT0, r0);
    write_reg(REG_ROT1, r1);
    write_reg(REG_ROT2, r2);
    write_reg(REG_TRANS, tr);
    cfg_write <= 1'b0;
  endtask

  // Offer one point and hold it until the transfer
  task automatic send_point(int px, int py, int pz);
    if (!quiet && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    point <= '{point_x: px, point_y: py, point_z: pz};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly points in front of the camera, within a rough view cone; the rest
  // are raw 32-bit noise
  task automatic random_points(int count);
    longint z, x, y;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 7) begin
        z = $urandom_range(30 << 16, 1 << 12);
        x = longint'($urandom_range(32'(z))) - z / 2;
        y = longint'($urandom_range(32'(z))) - z / 2;
        send_point(int'(x), int'(y), int'(z));
      end else begin
        send_point($urandom, $urandom, $urandom);
      end
    end
  endtask

  localparam int FX = 89420595;   // 1364.45 px
  localparam int FY = 89552326;   // 1366.46 px
  localparam int CX = 62804918;   // 958.327 px
  localparam int CY = 35066610;   // 535.074 px
  localparam int COS_YAW = 65410;
  localparam int SIN_YAW = -2872;
  localparam logic [INDEX_W-1:0] REG_UNUSED = 3'd7;

  initial begin
    logic [63:0] real_foc, real_ctr, real_size;
    real_foc = {32'(FY), 32'(FX)};
    real_ctr = {8'd0, 28'(CY), 28'(CX)};
    real_size = {40'd0, 12'd480, 12'd640};

    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: zero focal and centre, so every positive depth passes
    send_point(0, 0, 1);
    send_point(0, 0, 0);
    send_point(0, 0, -1);
    send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_point(32'h80000000, 32'h80000000, 32'h80000000);
    send_point(32'h80000000, 32'h7fffffff, 32'h00010000);
    send_point(-1, -1, -1);
    send_point(32'h00008000, -32'h00008000, 32'h00000001);
    random_points(150);

    // Realistic camera with a small yaw and offset
    set_camera(real_foc, real_ctr, real_size,
               rot_row(COS_YAW, 0, SIN_YAW), rot_row(0, 65536, 0),
               rot_row(-SIN_YAW, 0, COS_YAW), trans_triple(14164, -2872, 0));
    send_point(0, 0, 65536);
    send_point(0, 0, -65536);
    send_point(-32'd50000, -32'd30000, 65536);
    send_point(32'd30000, 32'd20000, 65536);
    send_point(32'h7fffffff, 0, 32'h00010000);
    random_points(150);
    // Hold off the sender until every visible point has come out
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    random_points(150);

    // Extremes: largest coefficients, focal, centre and image; saturation
    set_camera(64'hffffffffffffffff, 64'h00ffffffffffffff, 64'h0000000000ffffff,
               rot_row(32'h1ffff, 32'h1ffff, 32'h1ffff),
               rot_row(-32'h20000, -32'h20000, -32'h20000),
               rot_row(32'h1ffff, 0, 32'h1ffff),
               trans_triple(32'hfffff, -32'h100000, 32'hfffff));
    send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_point(32'h80000000, 32'h80000000, 32'h80000000);
    send_point(0, 0, 0);
    send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    random_points(150);

    // Zero width: nothing may pass; the out-of-range index must change nothing
    set_camera(real_foc, real_ctr, 64'h000001e0_00000000 >> 20,
               rot_row(65536, 0, 0), rot_row(0, 65536, 0), rot_row(0, 0, 65536),
               trans_triple(0, 0, 0));
    write_reg(REG_UNUSED, rand64());
    cfg_write <= 1'b0;
    random_points(100);

    // Random settings
    for (int k = 0; k < 2; k++) begin
      set_camera({$urandom_range(32'h0fffffff), $urandom_range(32'h0fffffff)},
                 rand64(), {40'd0, 12'($urandom_range(4095, 1)),
                 12'($urandom_range(4095, 1))},
                 rand64(), rand64(), rand64(), rand64());
      random_points(75);
    end

    // Realistic camera again, flat out with no idling
    set_camera(real_foc, real_ctr, real_size,
               rot_row(65536, 0, 0), rot_row(0, 65536, 0), rot_row(0, 0, 65536),
               trans_triple(-14164, 0, 65536));
    quiet = 1'b1;
    random_points(200);

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+sv
sv/ptpc_pkg.sv
sv/ptpc_front.sv
sv/ptpc_queue.sv
sv/ptpc_back.sv
sv/point_transform_pinhole_cull.sv
sv/ptpc_checker.sv
test/point_transform_pinhole_cull_checker.sv
test/point_transform_pinhole_cull_tb.sv
